// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cfd_pkg.sv =====
`default_nettype none
package cfd_pkg;

   // frame layout
   localparam logic [15:0] HEADER_BYTES = 16'd32;
   localparam logic [15:0] CRC_FIELD_AT = 16'd28;
   localparam logic [15:0] PAYLOAD_MAX  = 16'd224;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

   typedef logic [1:0] status_type;

   // verdict status codes
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_SIZE   = 2'd1;
   localparam status_type STATUS_HEADER = 2'd2;
   localparam status_type STATUS_CRC    = 2'd3;

   typedef logic [1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_MAGIC   = 2'd0;
   localparam csr_index_type CSR_VERSION = 2'd1;
   localparam csr_index_type CSR_NOP     = 2'd2;

   // one entry of the result queue
   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [7:0]  frame_type;
      logic [15:0] payload_length;
      logic [31:0] sequence_number;
      logic [31:0] flag_bits;
      logic [63:0] source_time_us;
      logic        deliver;
      logic [31:0] crc_error_count;
      logic [31:0] bad_frame_count;
      logic [31:0] good_frame_count;
   } rsp_item_type;

   // reflected crc-32, one byte unrolled over eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cfd_channels.sv =====
`default_nettype none
// byte request channel
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_transfer;
   modport source (output valid, output frame_byte, output end_of_transfer, input ready);
   modport sink   (input valid, input frame_byte, input end_of_transfer, output ready);
endinterface

// result channel
interface cfd_rsp_if;
   logic                valid;
   logic                ready;
   logic                is_verdict;
   logic [7:0]          payload_byte;
   cfd_pkg::status_type status;
   logic [7:0]          frame_type;
   logic [15:0]         payload_length;
   logic [31:0]         sequence_number;
   logic [31:0]         flag_bits;
   logic [63:0]         source_time_us;
   logic                deliver;
   logic [31:0]         crc_error_count;
   logic [31:0]         bad_frame_count;
   logic [31:0]         good_frame_count;
   modport source (output valid, output is_verdict, output payload_byte, output status,
                   output frame_type, output payload_length, output sequence_number,
                   output flag_bits, output source_time_us, output deliver,
                   output crc_error_count, output bad_frame_count,
                   output good_frame_count, input ready);
   modport sink   (input valid, input is_verdict, input payload_byte, input status,
                   input frame_type, input payload_length, input sequence_number,
                   input flag_bits, input source_time_us, input deliver,
                   input crc_error_count, input bad_frame_count,
                   input good_frame_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/crc_checked_frame_decoder_unit.sv =====
// Frame decoder with header check and CRC-32.
// req_chan carries one raw byte per request, end_of_transfer on the last byte.
// rsp_chan returns payload byte items for every byte at offset 32 + k with
// k below the declared payload length, and one verdict item after the last
// byte of a transfer (after that byte's payload item, if it has one).
// csr_* writes magic word, protocol version and keepalive type; write only
// while no request is in flight.
// Results enter the result queue when their request is taken.
// Throughput: one byte per cycle while req_chan is ready; the byte-wide CRC
// update, header capture and verdict all settle in the cycle the byte is taken.
// Results sit in a four-entry queue; req_chan.ready drops once three or more
// entries are taken, so a stalled receiver backs up the sender once three
// results wait and nothing is lost.
// Reset (synchronous, active high) clears the registers, header holds,
// counters, CRC (to all ones) and empties the queue.
`default_nettype none
`include "assert_macros.svh"
module crc_checked_frame_decoder_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cfd_req_if.sink                     req_chan,
   cfd_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire cfd_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_write_data
);

   localparam int RSP_SLOTS = 4;
   localparam int PTR_W     = $clog2(RSP_SLOTS);
   localparam int CNT_W     = $clog2(RSP_SLOTS + 1);

   // configuration registers
   logic [31:0] magic_word_ff;
   logic [7:0]  protocol_version_ff;
   logic [7:0]  nop_type_ff;

   // per-frame state
   logic [15:0] byte_position_ff, byte_position_in;
   logic [31:0] running_crc_ff, running_crc_in;
   logic [31:0] magic_hold_ff, magic_hold_in;
   logic [7:0]  version_hold_ff, version_hold_in;
   logic [7:0]  type_hold_ff, type_hold_in;
   logic [15:0] header_length_ff, header_length_in;
   logic [15:0] declared_payload_ff, declared_payload_in;
   logic [31:0] sequence_hold_ff, sequence_hold_in;
   logic [31:0] flags_hold_ff, flags_hold_in;
   logic [63:0] time_hold_ff, time_hold_in;
   logic [31:0] received_crc_ff, received_crc_in;

   // totals
   logic [31:0] crc_fail_total_ff, crc_fail_total_in;
   logic [31:0] bad_total_ff, bad_total_in;
   logic [31:0] good_total_ff, good_total_in;

   // result queue
   cfd_pkg::rsp_item_type queue_mem [RSP_SLOTS];
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  req_accept;
   logic                  rsp_pop;
   logic                  in_header;
   logic                  in_crc_field;
   logic                  payload_hit;
   logic                  last_byte;
   logic                  frame_end;
   logic [7:0]            crc_data;
   logic [15:0]           payload_offset;
   logic [16:0]           total_bytes;
   logic [31:0]           tally_sum;
   cfd_pkg::status_type   verdict_status;
   logic [1:0]            push_count;
   cfd_pkg::rsp_item_type payload_item;
   cfd_pkg::rsp_item_type verdict_item;
   cfd_pkg::rsp_item_type first_item;

   // handshakes
   assign req_chan.ready = (count_ff <= CNT_W'(RSP_SLOTS - 2));
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_pop        = rsp_chan.valid && rsp_chan.ready;
   assign last_byte      = req_chan.end_of_transfer;
   assign frame_end      = req_accept && last_byte;

   // position decode
   assign in_header      = (byte_position_ff < cfd_pkg::HEADER_BYTES);
   assign in_crc_field   = in_header && (byte_position_ff >= cfd_pkg::CRC_FIELD_AT);
   assign payload_offset = byte_position_ff - cfd_pkg::HEADER_BYTES;
   assign payload_hit    = !in_header && (payload_offset < declared_payload_ff);
   assign crc_data       = in_crc_field ? 8'd0 : req_chan.frame_byte;
   assign total_bytes    = {1'b0, byte_position_ff} + 17'd1;

   // header capture and crc update
   always_comb begin
      magic_hold_in       = magic_hold_ff;
      version_hold_in     = version_hold_ff;
      type_hold_in        = type_hold_ff;
      header_length_in    = header_length_ff;
      declared_payload_in = declared_payload_ff;
      sequence_hold_in    = sequence_hold_ff;
      flags_hold_in       = flags_hold_ff;
      time_hold_in        = time_hold_ff;
      received_crc_in     = received_crc_ff;
      running_crc_in      = running_crc_ff;
      if (in_header) begin
         case (byte_position_ff[4:0]) inside
            [5'd0:5'd3]:   magic_hold_in[8*byte_position_ff[1:0] +: 8] = req_chan.frame_byte;
            5'd4:          version_hold_in = req_chan.frame_byte;
            5'd5:          type_hold_in = req_chan.frame_byte;
            [5'd6:5'd7]:   header_length_in[8*byte_position_ff[0] +: 8] = req_chan.frame_byte;
            [5'd8:5'd9]:   declared_payload_in[8*byte_position_ff[0] +: 8] = req_chan.frame_byte;
            [5'd12:5'd15]: sequence_hold_in[8*byte_position_ff[1:0] +: 8] = req_chan.frame_byte;
            [5'd16:5'd19]: flags_hold_in[8*byte_position_ff[1:0] +: 8] = req_chan.frame_byte;
            [5'd20:5'd27]: begin
               // offsets 20..27 land in timestamp bytes 0..7
               time_hold_in[8*{~byte_position_ff[2], byte_position_ff[1:0]} +: 8] =
                  req_chan.frame_byte;
            end
            [5'd28:5'd31]: received_crc_in[8*byte_position_ff[1:0] +: 8] = req_chan.frame_byte;
            default: ;
         endcase
      end
      if (in_header || payload_hit) begin
         running_crc_in = cfd_pkg::crc_byte(running_crc_ff, crc_data);
      end
   end

   // verdict from the state including this byte
   always_comb begin
      if (total_bytes < {1'b0, cfd_pkg::HEADER_BYTES}) begin
         verdict_status = cfd_pkg::STATUS_SIZE;
      end else if (magic_hold_in != magic_word_ff || version_hold_in != protocol_version_ff
                   || header_length_in != cfd_pkg::HEADER_BYTES) begin
         verdict_status = cfd_pkg::STATUS_HEADER;
      end else if (declared_payload_in > cfd_pkg::PAYLOAD_MAX
                   || ({1'b0, cfd_pkg::HEADER_BYTES} + {1'b0, declared_payload_in})
                      > total_bytes) begin
         verdict_status = cfd_pkg::STATUS_SIZE;
      end else if (~running_crc_in != received_crc_in) begin
         verdict_status = cfd_pkg::STATUS_CRC;
      end else begin
         verdict_status = cfd_pkg::STATUS_OK;
      end
   end

   // totals after the verdict
   always_comb begin
      crc_fail_total_in = crc_fail_total_ff;
      bad_total_in      = bad_total_ff;
      good_total_in     = good_total_ff;
      if (frame_end) begin
         case (verdict_status)
            cfd_pkg::STATUS_CRC: crc_fail_total_in = crc_fail_total_ff + 32'd1;
            cfd_pkg::STATUS_OK:  good_total_in = good_total_ff + 32'd1;
            default:             bad_total_in = bad_total_ff + 32'd1;
         endcase
      end
   end

   // result items
   always_comb begin
      payload_item              = '0;
      payload_item.payload_byte = req_chan.frame_byte;

      verdict_item                  = '0;
      verdict_item.is_verdict       = 1'b1;
      verdict_item.status           = verdict_status;
      verdict_item.frame_type       = type_hold_in;
      verdict_item.payload_length   = declared_payload_in;
      verdict_item.sequence_number  = sequence_hold_in;
      verdict_item.flag_bits        = flags_hold_in;
      verdict_item.source_time_us   = time_hold_in;
      verdict_item.deliver          = (verdict_status == cfd_pkg::STATUS_OK)
                                      && (type_hold_in != nop_type_ff);
      verdict_item.crc_error_count  = crc_fail_total_in;
      verdict_item.bad_frame_count  = bad_total_in;
      verdict_item.good_frame_count = good_total_in;

      first_item = payload_hit ? payload_item : verdict_item;
      push_count = req_accept ? ({1'b0, payload_hit} + {1'b0, last_byte}) : 2'd0;
   end

   // next position, saturating
   always_comb begin
      byte_position_in = byte_position_ff;
      if (byte_position_ff != 16'hFFFF) begin
         byte_position_in = byte_position_ff + 16'd1;
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_pop);
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(rsp_pop);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff       <= '0;
         protocol_version_ff <= '0;
         nop_type_ff         <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cfd_pkg::CSR_MAGIC:   magic_word_ff <= csr_write_data;
            cfd_pkg::CSR_VERSION: protocol_version_ff <= csr_write_data[7:0];
            cfd_pkg::CSR_NOP:     nop_type_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // frame state and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff    <= '0;
         running_crc_ff      <= cfd_pkg::CRC_INIT;
         magic_hold_ff       <= '0;
         version_hold_ff     <= '0;
         type_hold_ff        <= '0;
         header_length_ff    <= '0;
         declared_payload_ff <= '0;
         sequence_hold_ff    <= '0;
         flags_hold_ff       <= '0;
         time_hold_ff        <= '0;
         received_crc_ff     <= '0;
         crc_fail_total_ff   <= '0;
         bad_total_ff        <= '0;
         good_total_ff       <= '0;
      end else if (req_accept) begin
         crc_fail_total_ff <= crc_fail_total_in;
         bad_total_ff      <= bad_total_in;
         good_total_ff     <= good_total_in;
         if (last_byte) begin
            byte_position_ff    <= '0;
            running_crc_ff      <= cfd_pkg::CRC_INIT;
            magic_hold_ff       <= '0;
            version_hold_ff     <= '0;
            type_hold_ff        <= '0;
            header_length_ff    <= '0;
            declared_payload_ff <= '0;
            sequence_hold_ff    <= '0;
            flags_hold_ff       <= '0;
            time_hold_ff        <= '0;
            received_crc_ff     <= '0;
         end else begin
            byte_position_ff    <= byte_position_in;
            running_crc_ff      <= running_crc_in;
            magic_hold_ff       <= magic_hold_in;
            version_hold_ff     <= version_hold_in;
            type_hold_ff        <= type_hold_in;
            header_length_ff    <= header_length_in;
            declared_payload_ff <= declared_payload_in;
            sequence_hold_ff    <= sequence_hold_in;
            flags_hold_ff       <= flags_hold_in;
            time_hold_ff        <= time_hold_in;
            received_crc_ff     <= received_crc_in;
         end
      end
   end

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, up to two entries written per request
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_mem[wr_ptr_ff] <= first_item;
      end
      if (push_count == 2'd2) begin
         queue_mem[wr_ptr_ff + PTR_W'(1)] <= verdict_item;
      end
   end

   // result channel
   assign rsp_chan.valid            = (count_ff != '0);
   assign rsp_chan.is_verdict       = queue_mem[rd_ptr_ff].is_verdict;
   assign rsp_chan.payload_byte     = queue_mem[rd_ptr_ff].payload_byte;
   assign rsp_chan.status           = queue_mem[rd_ptr_ff].status;
   assign rsp_chan.frame_type       = queue_mem[rd_ptr_ff].frame_type;
   assign rsp_chan.payload_length   = queue_mem[rd_ptr_ff].payload_length;
   assign rsp_chan.sequence_number  = queue_mem[rd_ptr_ff].sequence_number;
   assign rsp_chan.flag_bits        = queue_mem[rd_ptr_ff].flag_bits;
   assign rsp_chan.source_time_us   = queue_mem[rd_ptr_ff].source_time_us;
   assign rsp_chan.deliver          = queue_mem[rd_ptr_ff].deliver;
   assign rsp_chan.crc_error_count  = queue_mem[rd_ptr_ff].crc_error_count;
   assign rsp_chan.bad_frame_count  = queue_mem[rd_ptr_ff].bad_frame_count;
   assign rsp_chan.good_frame_count = queue_mem[rd_ptr_ff].good_frame_count;

   // sum of the three totals, grows by one per verdict
   assign tally_sum = crc_fail_total_ff + bad_total_ff + good_total_ff;

   // checks
   `CFD_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RSP_SLOTS))
   `CFD_ASSERT_NEXT(a_pos_restart, clock, reset, frame_end, byte_position_ff == 16'd0)
   `CFD_ASSERT_NEXT(a_crc_restart, clock, reset, frame_end, running_crc_ff == cfd_pkg::CRC_INIT)
   `CFD_ASSERT_NEXT(a_one_total, clock, reset, frame_end, tally_sum == $past(tally_sum) + 32'd1)

endmodule
`default_nettype wire

// ===== test/crc_checked_frame_decoder_unit_tb.sv =====
`default_nettype none
module crc_checked_frame_decoder_unit_tb;

   localparam int unsigned CYCLE_LIMIT = 200_000;

   // one byte waiting to be offered on the request channel
   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } wire_byte_type;

   typedef enum logic [1:0] {
      FAULT_NONE, FAULT_MAGIC, FAULT_VERSION, FAULT_HDR_LEN
   } header_fault_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} sink_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   cfd_pkg::csr_index_type csr_index;
   logic [31:0]            csr_write_data;

   cfd_req_if req_if ();
   cfd_rsp_if rsp_if ();

   crc_checked_frame_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted decoder state and register copies
   logic [31:0]  cfg_magic;
   logic [7:0]   cfg_version;
   logic [7:0]   cfg_nop;
   int unsigned  frame_pos;
   logic [31:0]  frame_crc;
   logic [7:0]   header_bytes [32];
   logic [31:0]  crc_fail_tally;
   logic [31:0]  bad_tally;
   logic [31:0]  good_tally;

   wire_byte_type         bytes_to_send [$];
   cfd_pkg::rsp_item_type frame_outputs_due [$];
   int unsigned           bytes_queued_total;
   int unsigned           error_count;
   int unsigned           cycle_count;
   bit                    byte_taken;
   int unsigned           sink_hold_request;

   // reflected crc-32, one data bit at a time
   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
      logic [31:0] s;
      s = acc;
      for (int i = 0; i < 8; i++) begin
         s = (s[0] ^ data[i]) ? ((s >> 1) ^ cfd_pkg::CRC_POLY) : (s >> 1);
      end
      return s;
   endfunction

   // works out what one accepted request byte produces
   function automatic void decode_byte(input logic [7:0] b, input logic is_last);
      cfd_pkg::rsp_item_type r;
      int unsigned           total;
      logic [15:0]           plen;
      logic [31:0]           magic;
      logic [31:0]           stored;
      logic [15:0]           hlen;
      cfd_pkg::status_type   st;
      plen = {header_bytes[9], header_bytes[8]};
      if (frame_pos < cfd_pkg::HEADER_BYTES) begin
         header_bytes[frame_pos] = b;
         frame_crc = crc32_step(frame_crc, (frame_pos >= cfd_pkg::CRC_FIELD_AT) ? 8'h00 : b);
      end else if (frame_pos - cfd_pkg::HEADER_BYTES < plen) begin
         frame_crc = crc32_step(frame_crc, b);
         r = '0;
         r.payload_byte = b;
         frame_outputs_due.push_back(r);
      end
      total = frame_pos + 1;
      if (frame_pos < 16'hFFFF) frame_pos++;
      if (!is_last) return;

      // verdict, checks in priority order
      plen   = {header_bytes[9], header_bytes[8]};
      magic  = {header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]};
      hlen   = {header_bytes[7], header_bytes[6]};
      stored = {header_bytes[31], header_bytes[30], header_bytes[29], header_bytes[28]};
      if (total < cfd_pkg::HEADER_BYTES) st = cfd_pkg::STATUS_SIZE;
      else if (magic != cfg_magic || header_bytes[4] != cfg_version
               || hlen != cfd_pkg::HEADER_BYTES)
         st = cfd_pkg::STATUS_HEADER;
      else if (plen > cfd_pkg::PAYLOAD_MAX || cfd_pkg::HEADER_BYTES + plen > total)
         st = cfd_pkg::STATUS_SIZE;
      else if (~frame_crc != stored) st = cfd_pkg::STATUS_CRC;
      else st = cfd_pkg::STATUS_OK;

      if (st == cfd_pkg::STATUS_CRC) crc_fail_tally++;
      else if (st != cfd_pkg::STATUS_OK) bad_tally++;
      else good_tally++;

      r = '0;
      r.is_verdict       = 1'b1;
      r.status           = st;
      r.frame_type       = header_bytes[5];
      r.payload_length   = plen;
      r.sequence_number  = {header_bytes[15], header_bytes[14], header_bytes[13], header_bytes[12]};
      r.flag_bits        = {header_bytes[19], header_bytes[18], header_bytes[17], header_bytes[16]};
      r.source_time_us   = {header_bytes[27], header_bytes[26], header_bytes[25], header_bytes[24],
                            header_bytes[23], header_bytes[22], header_bytes[21], header_bytes[20]};
      r.deliver          = (st == cfd_pkg::STATUS_OK) && (header_bytes[5] != cfg_nop);
      r.crc_error_count  = crc_fail_tally;
      r.bad_frame_count  = bad_tally;
      r.good_frame_count = good_tally;
      frame_outputs_due.push_back(r);

      // per-frame state back to idle
      frame_pos = 0;
      frame_crc = cfd_pkg::CRC_INIT;
      foreach (header_bytes[i]) header_bytes[i] = 8'h00;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   // request sampling, prediction and result checking at the rising edge
   always @(posedge clock) begin : watch
      cfd_pkg::rsp_item_type due;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.frame_byte, req_if.end_of_transfer);
            void'(bytes_to_send.pop_front());
            byte_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_outputs_due.size() == 0) begin
               $error("result with nothing expected");
               error_count++;
            end else begin
               due = frame_outputs_due.pop_front();
               check_field("is_verdict", due.is_verdict, rsp_if.is_verdict);
               check_field("payload_byte", due.payload_byte, rsp_if.payload_byte);
               check_field("status", due.status, rsp_if.status);
               check_field("frame_type", due.frame_type, rsp_if.frame_type);
               check_field("payload_length", due.payload_length, rsp_if.payload_length);
               check_field("sequence_number", due.sequence_number, rsp_if.sequence_number);
               check_field("flag_bits", due.flag_bits, rsp_if.flag_bits);
               check_field("source_time_us", due.source_time_us, rsp_if.source_time_us);
               check_field("deliver", due.deliver, rsp_if.deliver);
               check_field("crc_error_count", due.crc_error_count, rsp_if.crc_error_count);
               check_field("bad_frame_count", due.bad_frame_count, rsp_if.bad_frame_count);
               check_field("good_frame_count", due.good_frame_count, rsp_if.good_frame_count);
            end
         end
      end
   end

   // request driver: bursts of random length with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         byte_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (bytes_to_send.size() == 0) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid           <= 1'b1;
            req_if.frame_byte      <= bytes_to_send[0].value;
            req_if.end_of_transfer <= bytes_to_send[0].is_last;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // result receiver: changing stall pattern plus an occasional long hold-off
   sink_mode_type sink_mode = RX_OPEN;
   int unsigned   sink_mode_left = 0;
   int unsigned   sink_hold_left = 0;
   int unsigned   sink_tick = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         sink_tick++;
         if (sink_hold_request != 0) begin
            sink_hold_left    = sink_hold_request;
            sink_hold_request = 0;
         end
         if (sink_hold_left > 0) begin
            sink_hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (sink_mode_left == 0) begin
               sink_mode      = sink_mode_type'($urandom_range(0, 3));
               sink_mode_left = $urandom_range(20, 200);
            end
            sink_mode_left--;
            case (sink_mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
               default:     rsp_if.ready <= (sink_tick % 3 != 0);
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_transfer(input logic [7:0] fb [$]);
      foreach (fb[i]) bytes_to_send.push_back(wire_byte_type'{fb[i], (i == fb.size() - 1)});
      bytes_queued_total += fb.size();
   endtask

   // builds one transfer around a header matching the current registers unless a header fault is asked for
   task automatic queue_frame(input logic [15:0] plen, input header_fault_type fault,
                              input bit bad_crc, input int unsigned keep,
                              input int unsigned trail, input bit as_nop);
      logic [7:0]  fb [$];
      logic [7:0]  pl [$];
      logic [31:0] magic, seq, flags, crc;
      logic [63:0] stamp;
      logic [7:0]  version, ftype;
      logic [15:0] hlen;
      int unsigned body;
      magic   = cfg_magic;
      version = cfg_version;
      hlen    = cfd_pkg::HEADER_BYTES;
      case (fault)
         FAULT_MAGIC:   magic   ^= 32'd1 << $urandom_range(0, 31);
         FAULT_VERSION: version ^= 8'd1 << $urandom_range(0, 7);
         FAULT_HDR_LEN: hlen    ^= 16'd1 << $urandom_range(0, 15);
         default: ;
      endcase
      ftype = as_nop ? cfg_nop : 8'($urandom);
      seq   = $urandom;
      flags = $urandom;
      stamp = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) fb.push_back(magic[8*i +: 8]);
      fb.push_back(version);
      fb.push_back(ftype);
      fb.push_back(hlen[7:0]);
      fb.push_back(hlen[15:8]);
      fb.push_back(plen[7:0]);
      fb.push_back(plen[15:8]);
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) fb.push_back(seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) fb.push_back(flags[8*i +: 8]);
      for (int i = 0; i < 8; i++) fb.push_back(stamp[8*i +: 8]);

      // crc over header with the crc field as zeros, then the payload
      crc = cfd_pkg::CRC_INIT;
      foreach (fb[i]) crc = crc32_step(crc, fb[i]);
      repeat (4) crc = crc32_step(crc, 8'h00);
      body = (plen > cfd_pkg::PAYLOAD_MAX) ? $urandom_range(0, 40) : plen;
      repeat (body) pl.push_back(8'($urandom));
      foreach (pl[i]) crc = crc32_step(crc, pl[i]);
      crc = ~crc;
      if (bad_crc) crc ^= 32'd1 << $urandom_range(0, 31);
      for (int i = 0; i < 4; i++) fb.push_back(crc[8*i +: 8]);
      foreach (pl[i]) fb.push_back(pl[i]);
      repeat (trail) fb.push_back(8'($urandom));
      if (keep != 0) begin
         while (fb.size() > keep) void'(fb.pop_back());
      end
      send_transfer(fb);
   endtask

   task automatic queue_noise();
      logic [7:0] fb [$];
      repeat ($urandom_range(1, 70)) fb.push_back(8'($urandom));
      send_transfer(fb);
   endtask

   task automatic queue_random_frame();
      logic [15:0]      plen;
      header_fault_type fault;
      int unsigned      keep;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) plen = 16'($urandom_range(225, 65535));
      else if (pick < 14) plen = 16'($urandom_range(100, 224));
      else plen = 16'($urandom_range(0, 24));
      fault = FAULT_NONE;
      if ($urandom_range(0, 7) == 0) fault = header_fault_type'($urandom_range(1, 3));
      keep = 0;
      pick = $urandom_range(0, 15);
      if (pick == 0) keep = $urandom_range(1, 31);
      else if (pick == 1 && plen != 0 && plen <= cfd_pkg::PAYLOAD_MAX)
         keep = $urandom_range(32, 31 + plen);
      queue_frame(plen, fault, ($urandom_range(0, 7) == 0), keep,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0,
                  ($urandom_range(0, 5) == 0));
   endtask

   task automatic run_random_phase(input int unsigned budget);
      int unsigned target;
      target = bytes_queued_total + budget;
      while (bytes_queued_total < target) begin
         if ($urandom_range(0, 6) == 0) queue_noise();
         else queue_random_frame();
      end
   endtask

   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || frame_outputs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input cfd_pkg::csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         cfd_pkg::CSR_MAGIC:   cfg_magic   = value;
         cfd_pkg::CSR_VERSION: cfg_version = value[7:0];
         cfd_pkg::CSR_NOP:     cfg_nop     = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] magic, input logic [31:0] version,
                             input logic [31:0] nop);
      write_register(cfd_pkg::CSR_MAGIC, magic);
      write_register(cfd_pkg::CSR_VERSION, version);
      write_register(cfd_pkg::CSR_NOP, nop);
   endtask

   // stimulus sequence
   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.frame_byte      = 8'h00;
      req_if.end_of_transfer = 1'b0;
      rsp_if.ready           = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = cfd_pkg::CSR_MAGIC;
      csr_write_data         = 32'd0;
      cfg_magic              = 32'd0;
      cfg_version            = 8'd0;
      cfg_nop                = 8'd0;
      frame_pos              = 0;
      frame_crc              = cfd_pkg::CRC_INIT;
      foreach (header_bytes[i]) header_bytes[i] = 8'h00;
      crc_fail_tally         = 32'd0;
      bad_tally              = 32'd0;
      good_tally             = 32'd0;
      bytes_queued_total     = 0;
      error_count            = 0;
      cycle_count            = 0;
      byte_taken             = 1'b0;
      sink_hold_request      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under the reset register values
      queue_frame(0, FAULT_NONE, 0, 1, 0, 0);            // single byte transfer
      queue_frame(0, FAULT_NONE, 0, 31, 0, 0);           // one byte short of a header
      queue_frame(0, FAULT_NONE, 0, 0, 0, 0);            // bare header, ok
      queue_frame(3, FAULT_NONE, 0, 0, 0, 1);            // keepalive, not delivered
      queue_frame(2, FAULT_MAGIC, 0, 0, 0, 0);
      queue_frame(2, FAULT_VERSION, 0, 0, 0, 0);
      queue_frame(2, FAULT_HDR_LEN, 0, 0, 0, 0);
      queue_frame(5, FAULT_NONE, 1, 0, 0, 0);            // crc mismatch
      queue_frame(224, FAULT_NONE, 0, 0, 0, 0);          // largest payload
      queue_frame(225, FAULT_NONE, 0, 0, 0, 0);          // just over the limit
      queue_frame(16'hFFFF, FAULT_NONE, 0, 0, 0, 0);     // largest declared length
      queue_frame(10, FAULT_NONE, 0, 36, 0, 0);          // payload cut short
      queue_frame(4, FAULT_NONE, 0, 0, 9, 0);            // trailing bytes ignored
      queue_frame(0, FAULT_MAGIC, 0, 20, 0, 0);          // short wins over header
      queue_frame(300, FAULT_NONE, 1, 0, 0, 0);          // size wins over crc
      wait_drained();

      // all-ones registers, upper bits of the byte register writes set
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_frame(6, FAULT_NONE, 0, 0, 0, 1);
      queue_frame(6, FAULT_NONE, 0, 0, 0, 0);
      run_random_phase(100);
      wait_drained();

      // random registers, receiver holds off while the sender keeps offering
      set_config($urandom, $urandom, $urandom);
      queue_frame(200, FAULT_NONE, 0, 0, 0, 0);
      run_random_phase(100);
      @(posedge clock);
      sink_hold_request = 300;
      wait_drained();

      set_config(32'h0000_0000, 32'h0000_00FF, 32'h0000_0000);
      run_random_phase(100);
      wait_drained();

      // a long run of trailing bytes after a short payload
      set_config($urandom, $urandom, $urandom);
      run_random_phase(50);
      queue_frame(8, FAULT_NONE, 0, 0, 40, 0);
      run_random_phase(50);
      wait_drained();

      set_config(32'h8000_0001, 32'h0000_0080, 32'h0000_007F);
      run_random_phase(100);
      wait_drained();

      set_config($urandom, $urandom, $urandom);
      run_random_phase(100);
      wait_drained();

      repeat (8) @(posedge clock);
      if (frame_outputs_due.size() != 0) begin
         $error("%0d expected results never arrived", frame_outputs_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
